// ===== design/mi3_pkg.sv =====
`default_nettype none
package mi3_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int PROD_W        = 64;
    localparam int TRIP_W        = 97;
    localparam int DET_W         = 98;
    localparam int DMAG_W        = 97;
    localparam int COF_W         = 65;
    localparam int CMAG_W        = 64;
    localparam int QBITS         = 32;
    localparam int REM_W         = DMAG_W + QBITS + 1;
    localparam int TOL_W         = 17;
    localparam int ADDR_W        = 3;
    localparam int PDATA_W       = 32;

    localparam logic [TOL_W-1:0]  TOL_RESET    = TOL_W'(1);
    localparam logic [ADDR_W-1:0] ADDR_DET_TOL = ADDR_W'(0);

    typedef struct packed {
        logic signed [DATA_W-1:0] a00;
        logic signed [DATA_W-1:0] a01;
        logic signed [DATA_W-1:0] a02;
        logic signed [DATA_W-1:0] a10;
        logic signed [DATA_W-1:0] a11;
        logic signed [DATA_W-1:0] a12;
        logic signed [DATA_W-1:0] a20;
        logic signed [DATA_W-1:0] a21;
        logic signed [DATA_W-1:0] a22;
    } t_mat_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] r00;
        logic signed [DATA_W-1:0] r01;
        logic signed [DATA_W-1:0] r02;
        logic signed [DATA_W-1:0] r10;
        logic signed [DATA_W-1:0] r11;
        logic signed [DATA_W-1:0] r12;
        logic signed [DATA_W-1:0] r20;
        logic signed [DATA_W-1:0] r21;
        logic signed [DATA_W-1:0] r22;
        logic                     singular;
        logic                     saturated;
    } t_mat_out;

    // Operands handed to one divider lane.
    typedef struct packed {
        logic [CMAG_W-1:0] cmag;
        logic              neg;
        logic [DMAG_W-1:0] dmag;
    } t_lane_in;

endpackage
`default_nettype wire

// ===== design/mi3_det.sv =====
`default_nettype none
module mi3_det (
    input  wire logic                           i_clk,
    input  wire logic                           i_en,
    input  wire mi3_pkg::t_mat_in               i_mat,
    output logic signed [mi3_pkg::DET_W-1:0]    o_det
);

    localparam int DW = mi3_pkg::DATA_W;
    localparam int PW = mi3_pkg::PROD_W;
    localparam int TW = mi3_pkg::TRIP_W;
    localparam int SW = mi3_pkg::DET_W;

    logic signed [DW-1:0] w_x [6];
    logic signed [DW-1:0] w_y [6];
    logic signed [DW-1:0] w_z [6];

    logic signed [PW-1:0] r_ab [6];
    logic signed [DW-1:0] r_c1 [6];
    logic signed [PW-1:0] r_ph [6];
    logic signed [PW:0]   r_pl [6];
    logic signed [TW-1:0] r_t  [6];
    logic signed [SW-1:0] r_s0;
    logic signed [SW-1:0] r_s1;
    logic signed [SW-1:0] r_det;

    // Sarrus terms: the first three are added, the last three subtracted.
    always_comb begin
        w_x[0] = i_mat.a00; w_y[0] = i_mat.a11; w_z[0] = i_mat.a22;
        w_x[1] = i_mat.a01; w_y[1] = i_mat.a12; w_z[1] = i_mat.a20;
        w_x[2] = i_mat.a02; w_y[2] = i_mat.a10; w_z[2] = i_mat.a21;
        w_x[3] = i_mat.a02; w_y[3] = i_mat.a11; w_z[3] = i_mat.a20;
        w_x[4] = i_mat.a01; w_y[4] = i_mat.a10; w_z[4] = i_mat.a22;
        w_x[5] = i_mat.a00; w_y[5] = i_mat.a12; w_z[5] = i_mat.a21;
    end

    // The 64 by 32 bit product is split into a high and a low half.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 6; k++) begin
                r_ab[k] <= w_x[k] * w_y[k];
                r_c1[k] <= w_z[k];
                r_ph[k] <= $signed(r_ab[k][PW-1:DW]) * r_c1[k];
                r_pl[k] <= $signed({1'b0, r_ab[k][DW-1:0]}) * r_c1[k];
                r_t[k]  <= TW'($signed({r_ph[k], {DW{1'b0}}})) + TW'(r_pl[k]);
            end
            r_s0  <= SW'(r_t[0]) + SW'(r_t[1]) + SW'(r_t[2]);
            r_s1  <= SW'(r_t[3]) + SW'(r_t[4]) + SW'(r_t[5]);
            r_det <= r_s0 - r_s1;
        end
    end

    assign o_det = r_det;

endmodule
`default_nettype wire

// ===== design/mi3_div_lane.sv =====
`default_nettype none
module mi3_div_lane #(
    parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire mi3_pkg::t_lane_in          i_op,
    output logic [mi3_pkg::DATA_W-1:0]      o_res,
    output logic                            o_sat
);

    localparam int RW = mi3_pkg::REM_W;
    localparam int QB = mi3_pkg::QBITS;
    localparam int DM = mi3_pkg::DMAG_W;

    logic [RW-1:0] r_rem [QB+1];
    logic [QB-1:0] r_q   [QB+1];
    logic [DM-1:0] r_d   [QB+1];
    logic          r_neg [QB+1];
    logic          r_ovf [QB+1];
    logic [RW-1:0] w_num;
    logic [QB-1:0] w_mag;

    // The quotient cannot fit 32 bits when the numerator reaches D * 2^32.
    assign w_num = RW'(i_op.cmag) << (2 * FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= w_num;
            r_q[0]   <= '0;
            r_d[0]   <= i_op.dmag;
            r_neg[0] <= i_op.neg;
            r_ovf[0] <= w_num >= (RW'(i_op.dmag) << QB);
        end
    end

    // One restoring step per stage, most significant quotient bit first.
    for (genvar j = 1; j <= QB; j++) begin : g_step
        logic [RW-1:0] w_ds;
        logic          w_ge;
        assign w_ds = RW'(r_d[j-1]) << (QB - j);
        assign w_ge = r_rem[j-1] >= w_ds;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= w_ge ? r_rem[j-1] - w_ds : r_rem[j-1];
                r_q[j]   <= r_q[j-1] | (QB'(w_ge) << (QB - j));
                r_d[j]   <= r_d[j-1];
                r_neg[j] <= r_neg[j-1];
                r_ovf[j] <= r_ovf[j-1];
            end
        end
    end

    assign w_mag = r_q[QB];

    always_comb begin
        if (r_neg[QB]) begin
            o_sat = r_ovf[QB] || (w_mag > {1'b1, {(QB-1){1'b0}}});
            o_res = o_sat ? {1'b1, {(QB-1){1'b0}}} : (~w_mag + QB'(1));
        end else begin
            o_sat = r_ovf[QB] || w_mag[QB-1];
            o_res = o_sat ? {1'b0, {(QB-1){1'b1}}} : w_mag;
        end
    end

endmodule
`default_nettype wire

// ===== design/matrix_inverse_3x3.sv =====
// 3x3 matrix inverse through the adjugate, signed fixed point.
// Throughput: one matrix per cycle; the whole pipeline advances together
// and holds only while the output word is valid and stalled.
// Reset (synchronous, active low) empties the pipeline and sets the
// determinant tolerance to one.
`default_nettype none
module matrix_inverse_3x3 #(
    parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire mi3_pkg::t_mat_in               i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output mi3_pkg::t_mat_out                   o_out_data,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [mi3_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [mi3_pkg::PDATA_W-1:0]    pwdata,
    output logic [mi3_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready
);

    localparam int DW   = mi3_pkg::DATA_W;
    localparam int PW   = mi3_pkg::PROD_W;
    localparam int CW   = mi3_pkg::COF_W;
    localparam int SW   = mi3_pkg::DET_W;
    localparam int DM   = mi3_pkg::DMAG_W;
    localparam int CM   = mi3_pkg::CMAG_W;
    localparam int TW   = mi3_pkg::TOL_W;
    localparam int QB   = mi3_pkg::QBITS;
    // Input register, five determinant stages, the magnitude stage,
    // 33 divider stages and the output register.
    localparam int NST  = 41;
    localparam int SNGD = QB + 2;

    // Configuration: one register, written during the APB access phase.
    logic [TW-1:0] r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= mi3_pkg::TOL_RESET;
        end else if (psel && penable && pwrite && paddr == mi3_pkg::ADDR_DET_TOL) begin
            r_tol <= pwdata[TW-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == mi3_pkg::ADDR_DET_TOL) ? mi3_pkg::PDATA_W'(r_tol) : '0;

    // Every stage moves on together unless the finished word is held.
    logic w_en;
    logic [NST-1:0] r_vld;

    assign w_en       = !(r_vld[NST-1] && i_out_stall);
    assign o_in_stall = !w_en;
    assign o_out_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], i_in_valid};
        end
    end

    mi3_pkg::t_mat_in r_in;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in <= i_in_data;
        end
    end

    // Determinant by the rule of Sarrus, five stages deep.
    logic signed [SW-1:0] w_det;

    mi3_det u_det (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_mat (r_in),
        .o_det (w_det)
    );

    // Cofactors: nine pairs of products, one subtraction, then delayed so
    // that they meet the determinant.
    logic signed [DW-1:0] w_ca [9];
    logic signed [DW-1:0] w_cb [9];
    logic signed [DW-1:0] w_cc [9];
    logic signed [DW-1:0] w_cd [9];
    logic signed [PW-1:0] r_p0 [9];
    logic signed [PW-1:0] r_p1 [9];
    logic signed [CW-1:0] r_cof [4][9];

    always_comb begin
        w_ca[0] = r_in.a11; w_cb[0] = r_in.a22; w_cc[0] = r_in.a12; w_cd[0] = r_in.a21;
        w_ca[1] = r_in.a02; w_cb[1] = r_in.a21; w_cc[1] = r_in.a01; w_cd[1] = r_in.a22;
        w_ca[2] = r_in.a01; w_cb[2] = r_in.a12; w_cc[2] = r_in.a02; w_cd[2] = r_in.a11;
        w_ca[3] = r_in.a12; w_cb[3] = r_in.a20; w_cc[3] = r_in.a10; w_cd[3] = r_in.a22;
        w_ca[4] = r_in.a00; w_cb[4] = r_in.a22; w_cc[4] = r_in.a02; w_cd[4] = r_in.a20;
        w_ca[5] = r_in.a02; w_cb[5] = r_in.a10; w_cc[5] = r_in.a00; w_cd[5] = r_in.a12;
        w_ca[6] = r_in.a10; w_cb[6] = r_in.a21; w_cc[6] = r_in.a11; w_cd[6] = r_in.a20;
        w_ca[7] = r_in.a01; w_cb[7] = r_in.a20; w_cc[7] = r_in.a00; w_cd[7] = r_in.a21;
        w_ca[8] = r_in.a00; w_cb[8] = r_in.a11; w_cc[8] = r_in.a01; w_cd[8] = r_in.a10;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 9; k++) begin
                r_p0[k]     <= w_ca[k] * w_cb[k];
                r_p1[k]     <= w_cc[k] * w_cd[k];
                r_cof[0][k] <= CW'(r_p0[k]) - CW'(r_p1[k]);
                r_cof[1][k] <= r_cof[0][k];
                r_cof[2][k] <= r_cof[1][k];
                r_cof[3][k] <= r_cof[2][k];
            end
        end
    end

    // Magnitudes and signs for the dividers, and the singular test, which
    // compares the exact determinant with the tolerance scaled to its format.
    logic [DM-1:0]       w_dmag;
    logic [DM-1:0]       w_lim;
    mi3_pkg::t_lane_in   r_op [9];
    logic                r_sng [SNGD];

    assign w_dmag = w_det[SW-1] ? DM'(-w_det) : DM'(w_det);
    assign w_lim  = DM'(r_tol) << (2 * FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 9; k++) begin
                r_op[k].cmag <= r_cof[3][k][CW-1] ? CM'(-r_cof[3][k]) : CM'(r_cof[3][k]);
                r_op[k].neg  <= r_cof[3][k][CW-1] ^ w_det[SW-1];
                r_op[k].dmag <= w_dmag;
            end
            r_sng[0] <= w_dmag <= w_lim;
            for (int k = 1; k < SNGD; k++) begin
                r_sng[k] <= r_sng[k-1];
            end
        end
    end

    // Nine divider lanes, one per inverse entry.
    logic [DW-1:0] w_res [9];
    logic [8:0]    w_sat;

    for (genvar g = 0; g < 9; g++) begin : g_lane
        mi3_div_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_op  (r_op[g]),
            .o_res (w_res[g]),
            .o_sat (w_sat[g])
        );
    end

    // Merge: a singular matrix forces zeros, otherwise the lanes' flags
    // are combined into one saturation flag.
    mi3_pkg::t_mat_out r_out;
    logic              w_s;

    assign w_s = r_sng[SNGD-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.r00       <= w_s ? '0 : w_res[0];
            r_out.r01       <= w_s ? '0 : w_res[1];
            r_out.r02       <= w_s ? '0 : w_res[2];
            r_out.r10       <= w_s ? '0 : w_res[3];
            r_out.r11       <= w_s ? '0 : w_res[4];
            r_out.r12       <= w_s ? '0 : w_res[5];
            r_out.r20       <= w_s ? '0 : w_res[6];
            r_out.r21       <= w_s ? '0 : w_res[7];
            r_out.r22       <= w_s ? '0 : w_res[8];
            r_out.singular  <= w_s;
            r_out.saturated <= !w_s && (|w_sat);
        end
    end

    assign o_out_data = r_out;

endmodule
`default_nettype wire

// ===== sim/tb_matrix_inverse_3x3.sv =====
`default_nettype none
// Self-checking bench for the 3x3 adjugate matrix inverse.
// Matrices are sent over the valid/stall input channel, and each accepted word is
// run through a local predictor that works on exact 128-bit integers. The expected
// result is queued and then compared, field by field, with the words that come out.
// The determinant tolerance register is written through the APB port, but only
// while the pipeline is empty.
module tb_matrix_inverse_3x3;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC        = mi3_pkg::FRAC_BITS_DEF;
    localparam int PIPE_CYCLES = 41;
    localparam int SETTLE      = PIPE_CYCLES + 20;
    localparam int CYCLE_LIMIT = 600000;

    // Shapes of the random matrices.
    typedef enum int {
        MAT_WILD,
        MAT_UNIT_SCALE,
        MAT_DEPENDENT,
        MAT_TINY
    } t_mat_kind;

    logic                        i_clk      = 1'b0;
    logic                        i_rst_n    = 1'b0;
    logic                        i_in_valid = 1'b0;
    mi3_pkg::t_mat_in            i_in_data  = '0;
    logic                        i_out_stall = 1'b0;
    logic                        psel       = 1'b0;
    logic                        penable    = 1'b0;
    logic                        pwrite     = 1'b0;
    logic [mi3_pkg::ADDR_W-1:0]  paddr      = '0;
    logic [mi3_pkg::PDATA_W-1:0] pwdata     = '0;
    logic                        o_in_stall;
    logic                        o_out_valid;
    mi3_pkg::t_mat_out           o_out_data;
    logic [mi3_pkg::PDATA_W-1:0] prdata;
    logic                        pready;

    matrix_inverse_3x3 dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // The bench's own copy of the tolerance register, and the inverses that are
    // still waiting to come out, oldest first.
    logic [mi3_pkg::TOL_W-1:0] tol_copy = mi3_pkg::TOL_RESET;
    mi3_pkg::t_mat_out         pending_inverses[$];
    int                        fail_count   = 0;
    int                        cycle_count  = 0;
    bit                        sender_gaps  = 1'b1;
    bit                        sink_stalls  = 1'b1;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Exact inverse. The determinant and the cofactors are at most 97 and 65 bits
    // wide, so 128-bit arithmetic holds every step without loss.
    function automatic mi3_pkg::t_mat_out invert_exact(mi3_pkg::t_mat_in m,
                                                       logic [mi3_pkg::TOL_W-1:0] tol);
        logic signed [127:0] e[9];
        logic signed [127:0] cof[9];
        logic signed [127:0] det;
        logic [127:0]        det_mag;
        logic [127:0]        cof_mag;
        logic [127:0]        quo;
        logic [127:0]        lim;
        logic [31:0]         ent[9];
        logic                neg;
        logic                clipped;
        mi3_pkg::t_mat_out   r;
        e[0] = m.a00; e[1] = m.a01; e[2] = m.a02;
        e[3] = m.a10; e[4] = m.a11; e[5] = m.a12;
        e[6] = m.a20; e[7] = m.a21; e[8] = m.a22;
        // Sarrus: three products are added and three are subtracted.
        det = e[0]*e[4]*e[8] + e[1]*e[5]*e[6] + e[2]*e[3]*e[7]
            - e[2]*e[4]*e[6] - e[1]*e[3]*e[8] - e[0]*e[5]*e[7];
        det_mag = (det < 0) ? -det : det;
        lim = 128'(tol) << (2*FRAC);
        r = '0;
        if (det_mag <= lim) begin
            r.singular = 1'b1;
            return r;
        end
        // The adjugate is the transpose of the cofactor matrix.
        cof[0] = e[4]*e[8] - e[5]*e[7];
        cof[1] = e[2]*e[7] - e[1]*e[8];
        cof[2] = e[1]*e[5] - e[2]*e[4];
        cof[3] = e[5]*e[6] - e[3]*e[8];
        cof[4] = e[0]*e[8] - e[2]*e[6];
        cof[5] = e[2]*e[3] - e[0]*e[5];
        cof[6] = e[3]*e[7] - e[4]*e[6];
        cof[7] = e[1]*e[6] - e[0]*e[7];
        cof[8] = e[0]*e[4] - e[1]*e[3];
        clipped = 1'b0;
        for (int i = 0; i < 9; i++) begin
            neg     = (cof[i] < 0) != (det < 0);
            cof_mag = (cof[i] < 0) ? -cof[i] : cof[i];
            quo     = (cof_mag << (2*FRAC)) / det_mag;
            if (quo > (neg ? 128'h8000_0000 : 128'h7FFF_FFFF)) begin
                clipped = 1'b1;
                ent[i]  = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                ent[i] = neg ? 32'(-quo) : quo[31:0];
            end
        end
        r.r00 = ent[0]; r.r01 = ent[1]; r.r02 = ent[2];
        r.r10 = ent[3]; r.r11 = ent[4]; r.r12 = ent[5];
        r.r20 = ent[6]; r.r21 = ent[7]; r.r22 = ent[8];
        r.saturated = clipped;
        return r;
    endfunction

    task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Output side: the stall is drawn afresh for each word, and every accepted
    // word is checked against the oldest pending inverse.
    int stall_left = 0;
    always @(posedge i_clk) begin
        mi3_pkg::t_mat_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_inverses.size() == 0) begin
                $error("unexpected result word %h", o_out_data);
                fail_count++;
            end else begin
                want = pending_inverses.pop_front();
                compare_field("r00", want.r00, o_out_data.r00);
                compare_field("r01", want.r01, o_out_data.r01);
                compare_field("r02", want.r02, o_out_data.r02);
                compare_field("r10", want.r10, o_out_data.r10);
                compare_field("r11", want.r11, o_out_data.r11);
                compare_field("r12", want.r12, o_out_data.r12);
                compare_field("r20", want.r20, o_out_data.r20);
                compare_field("r21", want.r21, o_out_data.r21);
                compare_field("r22", want.r22, o_out_data.r22);
                compare_field("singular", 32'(want.singular), 32'(o_out_data.singular));
                compare_field("saturated", 32'(want.saturated), 32'(o_out_data.saturated));
            end
            stall_left = sink_stalls ? $urandom_range(0, 10) : 0;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Watchdog: it stops the run if the pipeline hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("matrix_inverse_3x3 verification failed");
            $finish;
        end
    end

    // Sends one word. The valid stays high between back-to-back words, so it is
    // lowered only when a gap is drawn.
    task automatic send_matrix(mi3_pkg::t_mat_in m);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= m;
        do @(posedge i_clk); while (o_in_stall);
        pending_inverses.push_back(invert_exact(m, tol_copy));
    endtask

    // Waits until every pending inverse has come out, then lets the pipeline settle.
    // The valid is lowered at the edge that took the last word.
    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        while (pending_inverses.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Writes the tolerance register and reads it back. The block is idle when
    // this is called.
    task automatic write_tolerance(logic [mi3_pkg::TOL_W-1:0] v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= mi3_pkg::ADDR_DET_TOL; pwdata <= mi3_pkg::PDATA_W'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        tol_copy = v;
        pwrite <= 1'b0; penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[mi3_pkg::TOL_W-1:0] !== v) begin
            $error("det_zero_tolerance readback: expected %h, got %h", v, prdata);
            fail_count++;
        end
        psel <= 1'b0; penable <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] small_q16();
        return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
    endfunction

    function automatic mi3_pkg::t_mat_in random_matrix(t_mat_kind kind);
        mi3_pkg::t_mat_in m;
        logic [31:0] e[9];
        for (int i = 0; i < 9; i++) begin
            case (kind)
                MAT_WILD: begin
                    e[i] = $urandom();
                end
                MAT_TINY: begin
                    e[i] = 32'($urandom_range(0, 64)) - 32'd32;
                end
                default: begin
                    e[i] = small_q16();
                end
            endcase
        end
        if (kind == MAT_DEPENDENT) begin
            // The third row is the sum of the first two, with a little noise, so that
            // the determinant is near the tolerance.
            for (int c = 0; c < 3; c++) begin
                e[6+c] = e[c] + e[3+c] + (($urandom_range(0, 3) == 0) ?
                         32'($urandom_range(0, 4)) - 32'd2 : 32'd0);
            end
        end
        m = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
        return m;
    endfunction

    function automatic mi3_pkg::t_mat_in diag_matrix(logic [31:0] d0, logic [31:0] d1,
                                                     logic [31:0] d2);
        mi3_pkg::t_mat_in m;
        m = '0;
        m.a00 = d0; m.a11 = d1; m.a22 = d2;
        return m;
    endfunction

    // Directed cases: identity, the zero matrix, the extreme entries, a diagonal
    // that overflows the result, negative scales and rows that repeat.
    task automatic test_directed();
        mi3_pkg::t_mat_in m;
        send_matrix(diag_matrix(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        send_matrix('0);
        send_matrix('1);
        send_matrix({9{32'h7FFF_FFFF}});
        send_matrix({9{32'h8000_0000}});
        send_matrix(diag_matrix(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        send_matrix(diag_matrix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_matrix(diag_matrix(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
        send_matrix(diag_matrix(32'h0000_0100, 32'h0000_0100, 32'h0000_0100));
        send_matrix(diag_matrix(32'h0000_0100, 32'h0001_0000, 32'h0100_0000));
        send_matrix(diag_matrix(32'hFFFF_0000, 32'h0002_0000, 32'hFFFE_0000));
        send_matrix(diag_matrix(32'h0000_8000, 32'h0000_8000, 32'h0000_8000));
        // The determinant is exactly the tolerance of one, and then just above it.
        send_matrix(diag_matrix(32'h0001_0000, 32'h0001_0000, 32'h0000_0001));
        send_matrix(diag_matrix(32'h0001_0000, 32'h0001_0000, 32'h0000_0002));
        m = '0;
        m.a01 = 32'h0001_0000; m.a12 = 32'hFFFF_0000; m.a20 = 32'h0003_0000;
        send_matrix(m);
        m = {32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
             32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
             32'h0004_0000, 32'h0005_0000, 32'h0007_0000};
        send_matrix(m);
        m = {32'h0002_0000, 32'hFFFF_0000, 32'h0000_0000,
             32'hFFFF_0000, 32'h0002_0000, 32'hFFFF_0000,
             32'h0000_0000, 32'hFFFF_0000, 32'h0002_0000};
        send_matrix(m);
        m = {32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF,
             32'hFFFF_0000, 32'h1234_5678, 32'h8765_4321,
             32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h0000_0001};
        send_matrix(m);
        drain_pipeline();
    endtask

    // The tolerance settings: zero, 65536, the widest 17-bit value and a random one. The
    // same four diagonal matrices, and then fresh random ones, are sent for each setting.
    task automatic test_tolerance_settings();
        logic [mi3_pkg::TOL_W-1:0] settings[4];
        settings = '{17'd0, 17'd65536, 17'h1FFFF, 17'($urandom_range(2, 65535))};
        foreach (settings[s]) begin
            write_tolerance(settings[s]);
            send_matrix(diag_matrix(32'h0001_0000, 32'h0001_0000, 32'h0000_0001));
            send_matrix(diag_matrix(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
            send_matrix(diag_matrix(32'h0001_0000, 32'h0001_0000, 32'h0001_0001));
            send_matrix(diag_matrix(32'h0001_0000, 32'h0001_0000, 32'h0000_0000));
            for (int i = 0; i < 20; i++)
                send_matrix(random_matrix(t_mat_kind'($urandom_range(0, 3))));
            drain_pipeline();
        end
        write_tolerance(mi3_pkg::TOL_RESET);
    endtask

    // The bulk of the random items, with each side's idling switched on and off.
    task automatic test_random_stream(int count, bit gaps, bit stalls);
        int pick;
        sender_gaps = gaps;
        sink_stalls = stalls;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 3)       send_matrix(random_matrix(MAT_WILD));
            else if (pick < 7)  send_matrix(random_matrix(MAT_UNIT_SCALE));
            else if (pick < 9)  send_matrix(random_matrix(MAT_DEPENDENT));
            else                send_matrix(random_matrix(MAT_TINY));
        end
        drain_pipeline();
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
    endtask

    // The sender stops partway through until every pending inverse has come out,
    // and then starts again.
    task automatic test_pause_mid_stream();
        for (int i = 0; i < 30; i++) send_matrix(random_matrix(MAT_UNIT_SCALE));
        i_in_valid <= 1'b0;
        while (pending_inverses.size() != 0) @(posedge i_clk);
        for (int i = 0; i < 30; i++) send_matrix(random_matrix(MAT_WILD));
        drain_pipeline();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_tolerance_settings();
        test_random_stream(300, 1'b1, 1'b1);
        test_random_stream(150, 1'b0, 1'b0);
        test_pause_mid_stream();
        write_tolerance(17'd4096);
        test_random_stream(150, 1'b1, 1'b0);
        write_tolerance(17'd0);
        test_random_stream(100, 1'b0, 1'b1);
        if (fail_count == 0) begin
            $display("matrix_inverse_3x3 verification clean");
        end else begin
            $display("matrix_inverse_3x3 verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
